// File: sv/cfi_instruction_stream_decoder_assert.svh
// Assertion macros shared by the checker of the call-frame decoder.
`ifndef CFI_INSTRUCTION_STREAM_DECODER_ASSERT_SVH
`define CFI_INSTRUCTION_STREAM_DECODER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define CISD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cisd check failed");

// Check a condition in the cycle after its trigger.
`define CISD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cisd check failed");

`endif

// File: sv/cisd_pkg.sv
package cisd_pkg;

  // Stream byte beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } byte_item_t;

  // Decoded record beat
  typedef struct packed {
    logic [7:0]         opcode;
    logic [31:0]        code_offset;
    logic [31:0]        reg_res;
    logic signed [63:0] operand;
    logic [15:0]        record_index;
    logic               stored;
    logic               last;
  } record_t;

  typedef enum logic [1:0] {
    SCALE_NONE,
    SCALE_CODE,
    SCALE_DATA
  } scale_e;

  // Parsed instruction passed from front to back
  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] regnum;
    logic [63:0] value;
    scale_e      scale;
    logic        last;
  } parse_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_CODE_ALIGN  = 8'd0;
  localparam logic [7:0] CFG_DATA_ALIGN  = 8'd1;
  localparam logic [7:0] CFG_MAX_RECORDS = 8'd2;

  // Opcode classes in the top two bits
  localparam logic [1:0] HI_ADVANCE = 2'b01;
  localparam logic [1:0] HI_OFFSET  = 2'b10;
  localparam logic [1:0] HI_RESTORE = 2'b11;

  // Extended opcodes
  localparam logic [7:0] OP_ADVANCE1     = 8'h02;
  localparam logic [7:0] OP_ADVANCE2     = 8'h03;
  localparam logic [7:0] OP_ADVANCE4     = 8'h04;
  localparam logic [7:0] OP_OFFSET_EXT   = 8'h05;
  localparam logic [7:0] OP_RESTORE_EXT  = 8'h06;
  localparam logic [7:0] OP_UNDEFINED    = 8'h07;
  localparam logic [7:0] OP_SAME_VALUE   = 8'h08;
  localparam logic [7:0] OP_REGISTER     = 8'h09;
  localparam logic [7:0] OP_DEF_CFA      = 8'h0c;
  localparam logic [7:0] OP_DEF_CFA_REG  = 8'h0d;
  localparam logic [7:0] OP_DEF_CFA_OFF  = 8'h0e;
  localparam logic [7:0] OP_DEF_CFA_EXPR = 8'h0f;
  localparam logic [7:0] OP_EXPRESSION   = 8'h10;
  localparam logic [7:0] OP_OFFSET_SF    = 8'h11;
  localparam logic [7:0] OP_VAL_EXPR     = 8'h16;

endpackage

// File: sv/cisd_front.sv
module cisd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  cisd_pkg::byte_item_t byte_data,
  output logic                push_valid,
  input  logic                push_ready,
  output cisd_pkg::parse_t    push_data
);

  typedef enum logic [2:0] {
    PH_OP, PH_REG, PH_UVAL, PH_SVAL, PH_FIX, PH_BLEN, PH_SKIP
  } phase_e;

  phase_e            phase, phase_next;
  logic [7:0]        op, op_next;
  logic [31:0]       regnum, regnum_next;
  logic [63:0]       value, value_next;
  cisd_pkg::scale_e  scale, scale_next;
  logic [63:0]       accum, accum_next;
  logic [6:0]        shift, shift_next;
  logic [63:0]       left, left_next;

  logic [7:0]  b;
  logic        accept;
  logic        done;
  logic        emit;
  logic [63:0] leb_acc;
  logic [6:0]  leb_sh;
  logic        leb_end;
  logic [63:0] fix_acc;
  logic [6:0]  fix_sh;
  logic [63:0] left_dec;
  logic [63:0] sval;

  assign b          = byte_data.data_byte;
  assign byte_ready = push_ready;
  assign accept     = byte_valid && byte_ready;

  // LEB and fixed-width byte gathering
  always_comb begin
    leb_acc = accum;
    fix_acc = accum;
    if (!shift[6]) begin
      leb_acc = accum | (64'(b[6:0]) << shift[5:0]);
      fix_acc = accum | (64'(b) << shift[5:0]);
    end
    leb_sh   = (shift > 7'd57) ? 7'd64 : shift + 7'd7;
    fix_sh   = (shift > 7'd56) ? 7'd64 : shift + 7'd8;
    leb_end  = !b[7];
    left_dec = (left != 64'd0) ? left - 64'd1 : 64'd0;
    sval     = leb_acc;
    if (!leb_sh[6] && b[6]) sval = leb_acc | (~64'd0 << leb_sh[5:0]);
  end

  // Decode one byte
  always_comb begin
    phase_next  = phase;
    op_next     = op;
    regnum_next = regnum;
    value_next  = value;
    scale_next  = scale;
    accum_next  = accum;
    shift_next  = shift;
    left_next   = left;
    done        = 1'b0;
    unique case (phase)
      PH_OP: begin
        op_next     = b;
        regnum_next = '0;
        value_next  = '0;
        scale_next  = cisd_pkg::SCALE_NONE;
        accum_next  = '0;
        shift_next  = '0;
        left_next   = '0;
        if (b[7:6] == cisd_pkg::HI_ADVANCE) begin
          value_next = 64'(b[5:0]);
          scale_next = cisd_pkg::SCALE_CODE;
          done       = 1'b1;
        end else if (b[7:6] == cisd_pkg::HI_OFFSET) begin
          regnum_next = 32'(b[5:0]);
          phase_next  = PH_UVAL;
        end else if (b[7:6] == cisd_pkg::HI_RESTORE) begin
          regnum_next = 32'(b[5:0]);
          done        = 1'b1;
        end else begin
          unique case (b) inside
            cisd_pkg::OP_ADVANCE1: begin
              left_next = 64'd1; phase_next = PH_FIX;
            end
            cisd_pkg::OP_ADVANCE2: begin
              left_next = 64'd2; phase_next = PH_FIX;
            end
            cisd_pkg::OP_ADVANCE4: begin
              left_next = 64'd4; phase_next = PH_FIX;
            end
            cisd_pkg::OP_OFFSET_EXT, cisd_pkg::OP_RESTORE_EXT, cisd_pkg::OP_UNDEFINED,
            cisd_pkg::OP_SAME_VALUE, cisd_pkg::OP_REGISTER, cisd_pkg::OP_DEF_CFA,
            cisd_pkg::OP_DEF_CFA_REG, cisd_pkg::OP_EXPRESSION, cisd_pkg::OP_OFFSET_SF,
            cisd_pkg::OP_VAL_EXPR:
              phase_next = PH_REG;
            cisd_pkg::OP_DEF_CFA_OFF:  phase_next = PH_UVAL;
            cisd_pkg::OP_DEF_CFA_EXPR: phase_next = PH_BLEN;
            default:                   done = 1'b1;
          endcase
        end
      end
      PH_REG: begin
        accum_next = leb_acc;
        shift_next = leb_sh;
        if (leb_end) begin
          regnum_next = leb_acc[31:0];
          accum_next  = '0;
          shift_next  = '0;
          unique case (op) inside
            cisd_pkg::OP_OFFSET_EXT, cisd_pkg::OP_REGISTER, cisd_pkg::OP_DEF_CFA:
              phase_next = PH_UVAL;
            cisd_pkg::OP_OFFSET_SF:
              phase_next = PH_SVAL;
            cisd_pkg::OP_EXPRESSION, cisd_pkg::OP_VAL_EXPR:
              phase_next = PH_BLEN;
            default: done = 1'b1;
          endcase
        end
      end
      PH_UVAL: begin
        accum_next = leb_acc;
        shift_next = leb_sh;
        if (leb_end) begin
          value_next = leb_acc;
          if (op[7:6] == cisd_pkg::HI_OFFSET || op == cisd_pkg::OP_OFFSET_EXT)
            scale_next = cisd_pkg::SCALE_DATA;
          else
            scale_next = cisd_pkg::SCALE_NONE;
          done = 1'b1;
        end
      end
      PH_SVAL: begin
        accum_next = leb_acc;
        shift_next = leb_sh;
        if (leb_end) begin
          value_next = sval;
          scale_next = cisd_pkg::SCALE_DATA;
          done       = 1'b1;
        end
      end
      PH_FIX: begin
        accum_next = fix_acc;
        shift_next = fix_sh;
        left_next  = left_dec;
        if (left_dec == 64'd0) begin
          value_next = {32'd0, fix_acc[31:0]};
          scale_next = cisd_pkg::SCALE_CODE;
          done       = 1'b1;
        end
      end
      PH_BLEN: begin
        accum_next = leb_acc;
        shift_next = leb_sh;
        if (leb_end) begin
          accum_next = '0;
          shift_next = '0;
          if (leb_acc == 64'd0) begin
            done = 1'b1;
          end else begin
            left_next  = leb_acc;
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        left_next = left_dec;
        if (left_dec == 64'd0) done = 1'b1;
      end
      default: begin
        phase_next = PH_OP;
        done       = 1'b1;
      end
    endcase
    emit = done || byte_data.end_of_stream;
    // Return to opcode phase after a record
    if (emit) begin
      phase_next = PH_OP;
      accum_next = '0;
      shift_next = '0;
      left_next  = '0;
    end
  end

  assign push_valid       = byte_valid && emit;
  assign push_data.opcode = op_next;
  assign push_data.regnum = regnum_next;
  assign push_data.value  = value_next;
  assign push_data.scale  = scale_next;
  assign push_data.last   = byte_data.end_of_stream;

  // Commit parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_OP;
      op     <= '0;
      regnum <= '0;
      value  <= '0;
      scale  <= cisd_pkg::SCALE_NONE;
      accum  <= '0;
      shift  <= '0;
      left   <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      op     <= op_next;
      regnum <= regnum_next;
      value  <= value_next;
      scale  <= scale_next;
      accum  <= accum_next;
      shift  <= shift_next;
      left   <= left_next;
    end
  end

endmodule

// File: sv/cisd_fifo.sv
module cisd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  cisd_pkg::parse_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output cisd_pkg::parse_t pop_data
);

  cisd_pkg::parse_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Write storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

// File: sv/cisd_back.sv
module cisd_back #(
  parameter int OFFSET_WIDTH = 32,
  parameter int INDEX_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cisd_pkg::parse_t  pop_data,
  input  logic [15:0]       code_align,
  input  logic [15:0]       data_align,
  input  logic [15:0]       max_records,
  output logic              rec_valid,
  input  logic              rec_ready,
  output cisd_pkg::record_t rec_data
);

  // Scaled instruction stage
  logic        s1_valid;
  logic [7:0]  s1_opcode;
  logic [31:0] s1_regnum;
  logic [63:0] s1_operand;
  logic        s1_last;

  logic [OFFSET_WIDTH-1:0] running;
  logic [INDEX_WIDTH-1:0]  count;

  logic [16:0] factor;
  logic [80:0] product;
  logic [63:0] scaled;
  logic        move;
  logic        load;
  logic        s1_adv;

  assign move      = s1_valid && (!rec_valid || rec_ready);
  assign pop_ready = !s1_valid || move;
  assign load      = pop_valid && pop_ready;

  // Scale by the selected alignment factor, low 64 bits kept
  always_comb begin
    if (pop_data.scale == cisd_pkg::SCALE_CODE) factor = {1'b0, code_align};
    else                                        factor = {data_align[15], data_align};
    product = 81'(pop_data.value) * 81'(factor);
    scaled  = product[63:0] - (factor[16] ? {pop_data.value[46:0], 17'd0} : 64'd0);
  end

  assign s1_adv = (s1_opcode[7:6] == cisd_pkg::HI_ADVANCE) ||
                  (s1_opcode == cisd_pkg::OP_ADVANCE1) ||
                  (s1_opcode == cisd_pkg::OP_ADVANCE2) ||
                  (s1_opcode == cisd_pkg::OP_ADVANCE4);

  // Stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_opcode  <= pop_data.opcode;
      s1_regnum  <= pop_data.regnum;
      s1_operand <= (pop_data.scale == cisd_pkg::SCALE_NONE) ? pop_data.value : scaled;
      s1_last    <= pop_data.last;
    end
    if (move) begin
      rec_data.opcode       <= s1_opcode;
      rec_data.code_offset  <= 32'(running);
      rec_data.reg_res      <= s1_regnum;
      rec_data.operand      <= s1_operand;
      rec_data.record_index <= 16'(count);
      rec_data.stored       <= 64'(count) < 64'(max_records);
      rec_data.last         <= s1_last;
    end
  end

  // Valid flags, running offset and record count
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rec_valid <= 1'b0;
      running   <= '0;
      count     <= '0;
    end else begin
      if (load)      s1_valid <= 1'b1;
      else if (move) s1_valid <= 1'b0;
      if (move)           rec_valid <= 1'b1;
      else if (rec_ready) rec_valid <= 1'b0;
      if (move) begin
        if (s1_last) begin
          running <= '0;
          count   <= '0;
        end else begin
          if (s1_adv) running <= running + OFFSET_WIDTH'(s1_operand);
          count <= count + INDEX_WIDTH'(1);
        end
      end
    end
  end

endmodule

// File: sv/cfi_instruction_stream_decoder.sv
// Call-frame instruction decoder. Takes one stream byte per cycle on the byte
// channel while the record channel does not back-pressure, and gives one record
// on the record channel for each byte that completes an instruction or is marked
// end_of_stream. Both channels sustain one beat per cycle when not stalled. The
// front parser is combinational, so after the edge that accepts its final byte
// a record passes the queue write, then the scaling multiplier stage, then the
// output register before it shows on the record channel. The 64 by 17 bit
// multiplier in the back stage sets the clock period. After a record marked last
// the code offset and record index restart from zero. Configuration writes are
// taken at once and apply to records scaled after them.
module cfi_instruction_stream_decoder #(
  parameter int OFFSET_WIDTH = 32,
  parameter int INDEX_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  cisd_pkg::byte_item_t byte_data,
  output logic                 rec_valid,
  input  logic                 rec_ready,
  output cisd_pkg::record_t    rec_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] code_align;
  logic [15:0] data_align;
  logic [15:0] max_records;

  logic             push_valid;
  logic             push_ready;
  cisd_pkg::parse_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  cisd_pkg::parse_t pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_align  <= 16'd1;
      data_align  <= 16'hfff8;
      max_records <= 16'hffff;
    end else if (cfg_valid) begin
      case (cfg_index)
        cisd_pkg::CFG_CODE_ALIGN:  code_align  <= cfg_data;
        cisd_pkg::CFG_DATA_ALIGN:  data_align  <= cfg_data;
        cisd_pkg::CFG_MAX_RECORDS: max_records <= cfg_data;
        default: ;
      endcase
    end
  end

  cisd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cisd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cisd_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .INDEX_WIDTH  (INDEX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .code_align  (code_align),
    .data_align  (data_align),
    .max_records (max_records),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec_data    (rec_data)
  );

endmodule

// File: sv/cisd_checker.sv
`include "cfi_instruction_stream_decoder_assert.svh"

module cisd_checker (
  input logic              clk,
  input logic              rst,
  input logic              rec_valid,
  input logic              rec_ready,
  input cisd_pkg::record_t rec_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [7:0]        cfg_index,
  input logic [15:0]       cfg_data
);

  logic        after_last;
  logic [15:0] max_seen;

  // Track stream starts and the record limit from the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b1;
      max_seen   <= 16'hffff;
    end else begin
      if (rec_valid && rec_ready) after_last <= rec_data.last;
      if (cfg_valid && cfg_ready && cfg_index == cisd_pkg::CFG_MAX_RECORDS)
        max_seen <= cfg_data;
    end
  end

  `CISD_ASSERT_NEXT(a_rec_hold, rec_valid && !rec_ready, rec_valid && $stable(rec_data))
  `CISD_ASSERT_NOW(a_stream_start, rec_valid && after_last, rec_data.record_index == 16'd0 && rec_data.code_offset == 32'd0)
  `CISD_ASSERT_NOW(a_stored_flag, rec_valid, rec_data.stored == (rec_data.record_index < max_seen))

endmodule

bind cfi_instruction_stream_decoder cisd_checker u_cisd_checker (.*);

// File: test/tb_cfi_instruction_stream_decoder.sv
module tb_cfi_instruction_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser phases of the predictor
  typedef enum int {
    PH_OPCODE,
    PH_REGNUM,
    PH_UVALUE,
    PH_SVALUE,
    PH_FIXED,
    PH_BLOCK_LEN,
    PH_BLOCK_SKIP
  } parse_phase_e;

  // Predicts decoded records from accepted bytes and checks returned records
  class cfi_scoreboard;
    bit [63:0]         code_factor;
    bit [63:0]         data_factor;
    bit [15:0]         record_limit;
    parse_phase_e      phase;
    bit [7:0]          cur_op;
    bit [63:0]         acc;
    int unsigned       shift;
    bit [31:0]         cur_reg;
    bit [63:0]         cur_value;
    bit [63:0]         skip_left;
    bit [31:0]         code_loc;
    bit [15:0]         rec_count;
    cisd_pkg::record_t pending_records[$];
    int                errors;
    int                records_seen;

    function void reset_state();
      code_factor = 64'd1;
      data_factor = {{48{1'b1}}, 16'hfff8};
      record_limit = 16'hffff;
      phase = PH_OPCODE;
      cur_op = '0;
      acc = '0;
      shift = 0;
      cur_reg = '0;
      cur_value = '0;
      skip_left = '0;
      code_loc = '0;
      rec_count = '0;
    endfunction

    function void write_reg(bit [7:0] index, bit [15:0] value);
      if (index == cisd_pkg::CFG_CODE_ALIGN) code_factor = {48'd0, value};
      else if (index == cisd_pkg::CFG_DATA_ALIGN) data_factor = {{48{value[15]}}, value};
      else if (index == cisd_pkg::CFG_MAX_RECORDS) record_limit = value;
    endfunction

    function bit take_leb(bit [7:0] b);
      if (shift < 64) acc |= {57'd0, b[6:0]} << shift;
      shift += 7;
      if (shift > 64) shift = 64;
      return !b[7];
    endfunction

    function bit is_advance(bit [7:0] op);
      return op[7:6] == cisd_pkg::HI_ADVANCE || op == cisd_pkg::OP_ADVANCE1 ||
             op == cisd_pkg::OP_ADVANCE2 || op == cisd_pkg::OP_ADVANCE4;
    endfunction

    // Advance the parser by one accepted beat, queue a record when one is due
    function void note_byte(cisd_pkg::byte_item_t it);
      bit [7:0]          b;
      bit                done;
      bit [63:0]         v;
      cisd_pkg::record_t rec;
      b = it.data_byte;
      done = 0;
      case (phase)
        PH_OPCODE: begin
          cur_op = b;
          cur_reg = '0;
          cur_value = '0;
          acc = '0;
          shift = 0;
          skip_left = '0;
          if (b[7:6] == cisd_pkg::HI_ADVANCE) begin
            cur_value = {58'd0, b[5:0]} * code_factor;
            done = 1;
          end else if (b[7:6] == cisd_pkg::HI_OFFSET) begin
            cur_reg = {26'd0, b[5:0]};
            phase = PH_UVALUE;
          end else if (b[7:6] == cisd_pkg::HI_RESTORE) begin
            cur_reg = {26'd0, b[5:0]};
            done = 1;
          end else if (b == cisd_pkg::OP_ADVANCE1 || b == cisd_pkg::OP_ADVANCE2 ||
                       b == cisd_pkg::OP_ADVANCE4) begin
            skip_left = (b == cisd_pkg::OP_ADVANCE1) ? 64'd1 :
                        ((b == cisd_pkg::OP_ADVANCE2) ? 64'd2 : 64'd4);
            phase = PH_FIXED;
          end else if (b == cisd_pkg::OP_OFFSET_EXT || b == cisd_pkg::OP_RESTORE_EXT ||
                       b == cisd_pkg::OP_UNDEFINED || b == cisd_pkg::OP_SAME_VALUE ||
                       b == cisd_pkg::OP_REGISTER || b == cisd_pkg::OP_DEF_CFA ||
                       b == cisd_pkg::OP_DEF_CFA_REG || b == cisd_pkg::OP_EXPRESSION ||
                       b == cisd_pkg::OP_OFFSET_SF || b == cisd_pkg::OP_VAL_EXPR) begin
            phase = PH_REGNUM;
          end else if (b == cisd_pkg::OP_DEF_CFA_OFF) begin
            phase = PH_UVALUE;
          end else if (b == cisd_pkg::OP_DEF_CFA_EXPR) begin
            phase = PH_BLOCK_LEN;
          end else begin
            done = 1;
          end
        end
        PH_REGNUM: begin
          if (take_leb(b)) begin
            cur_reg = acc[31:0];
            acc = '0;
            shift = 0;
            if (cur_op == cisd_pkg::OP_OFFSET_EXT || cur_op == cisd_pkg::OP_REGISTER ||
                cur_op == cisd_pkg::OP_DEF_CFA)
              phase = PH_UVALUE;
            else if (cur_op == cisd_pkg::OP_OFFSET_SF) phase = PH_SVALUE;
            else if (cur_op == cisd_pkg::OP_EXPRESSION || cur_op == cisd_pkg::OP_VAL_EXPR)
              phase = PH_BLOCK_LEN;
            else done = 1;
          end
        end
        PH_UVALUE: begin
          if (take_leb(b)) begin
            if (cur_op[7:6] == cisd_pkg::HI_OFFSET || cur_op == cisd_pkg::OP_OFFSET_EXT)
              cur_value = acc * data_factor;
            else cur_value = acc;
            done = 1;
          end
        end
        PH_SVALUE: begin
          if (take_leb(b)) begin
            v = acc;
            if (shift < 64 && b[6]) v |= ~64'd0 << shift;
            cur_value = v * data_factor;
            done = 1;
          end
        end
        PH_FIXED: begin
          if (shift < 64) acc |= {56'd0, b} << shift;
          shift += 8;
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) begin
            cur_value = {32'd0, acc[31:0]} * code_factor;
            done = 1;
          end
        end
        PH_BLOCK_LEN: begin
          if (take_leb(b)) begin
            v = acc;
            acc = '0;
            shift = 0;
            if (v == 0) done = 1;
            else begin
              skip_left = v;
              phase = PH_BLOCK_SKIP;
            end
          end
        end
        default: begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) done = 1;
        end
      endcase

      if (done || it.end_of_stream) begin
        rec.opcode = cur_op;
        rec.code_offset = code_loc;
        rec.reg_res = cur_reg;
        rec.operand = cur_value;
        rec.record_index = rec_count;
        rec.stored = rec_count < record_limit;
        rec.last = it.end_of_stream;
        pending_records.push_back(rec);
        if (is_advance(cur_op)) code_loc += cur_value[31:0];
        rec_count++;
        phase = PH_OPCODE;
        acc = '0;
        shift = 0;
        skip_left = '0;
        if (it.end_of_stream) begin
          code_loc = '0;
          rec_count = '0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_record(cisd_pkg::record_t got);
      cisd_pkg::record_t want;
      records_seen++;
      if (pending_records.size() == 0) begin
        report($sformatf("unexpected record op=%02h", got.opcode));
        return;
      end
      want = pending_records.pop_front();
      if (got.opcode !== want.opcode)
        report($sformatf("opcode got %02h want %02h", got.opcode, want.opcode));
      if (got.code_offset !== want.code_offset)
        report($sformatf("code_offset got %08h want %08h", got.code_offset, want.code_offset));
      if (got.reg_res !== want.reg_res)
        report($sformatf("reg_res got %08h want %08h", got.reg_res, want.reg_res));
      if (got.operand !== want.operand)
        report($sformatf("operand got %016h want %016h", got.operand, want.operand));
      if (got.record_index !== want.record_index)
        report($sformatf("record_index got %0d want %0d", got.record_index,
                         want.record_index));
      if (got.stored !== want.stored)
        report($sformatf("stored got %b want %b", got.stored, want.stored));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_ready;
  cisd_pkg::byte_item_t byte_data;
  logic                 rec_valid;
  logic                 rec_ready;
  cisd_pkg::record_t    rec_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [7:0]           cfg_index;
  logic [15:0]          cfg_data;

  cfi_scoreboard        sb;
  cisd_pkg::byte_item_t stream[$];
  bit                   calm;
  int                   bytes_sent;
  int                   rx_stall;

  cfi_instruction_stream_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_data  (rec_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hard stop if the run hangs
  initial begin
    #5ms;
    $display("timeout waiting for the decoder");
    $display("*** FAILED ***");
    $finish;
  end

  // Stall the record channel in random bursts
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      rec_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      rx_stall <= $urandom_range(0, 16);
      rec_ready <= 1'b0;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  // Check every record beat
  always @(posedge clk) begin
    if (!rst && rec_valid && rec_ready) sb.check_record(rec_data);
  end

  function void add(bit [7:0] b, bit eos = 0);
    cisd_pkg::byte_item_t it;
    it.data_byte = b;
    it.end_of_stream = eos;
    stream.push_back(it);
  endfunction

  function void add_uleb(bit [63:0] v, int pad);
    bit [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad > 0) b[7] = 1'b1;
      if (v == 0 && pad > 0) pad--;
      add(b);
    end while (b[7]);
  endfunction

  function void add_sleb(bit [63:0] v);
    bit [7:0] b;
    bit       more;
    do begin
      b = {1'b0, v[6:0]};
      v = $signed(v) >>> 7;
      more = !((v == 0 && !b[6]) || (v == '1 && b[6]));
      b[7] = more;
      add(b);
    end while (more);
  endfunction

  function bit [63:0] rand_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // Append one random instruction, sometimes cut short by end of stream
  function void add_random_instr();
    bit [7:0] op;
    int       start;
    int       cut;
    int       len;
    int       pick;
    start = stream.size();
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1: add({cisd_pkg::HI_ADVANCE, 6'($urandom)});
      2, 3: begin
        add({cisd_pkg::HI_OFFSET, 6'($urandom)});
        add_uleb(rand_value(), $urandom_range(0, 9) == 0 ? 3 : 0);
      end
      4: add({cisd_pkg::HI_RESTORE, 6'($urandom)});
      5: begin
        op = cisd_pkg::OP_ADVANCE1 + 8'($urandom_range(0, 2));
        add(op);
        repeat ((op == cisd_pkg::OP_ADVANCE1) ? 1 : ((op == cisd_pkg::OP_ADVANCE2) ? 2 : 4))
          add(8'($urandom));
      end
      6, 7: begin
        add(cisd_pkg::OP_OFFSET_EXT);
        add_uleb(rand_value(), 0);
        add_uleb(rand_value(), 0);
      end
      8: begin
        add(cisd_pkg::OP_OFFSET_SF);
        add_uleb(rand_value(), 0);
        add_sleb({$urandom, $urandom} >>> $urandom_range(0, 63));
      end
      9: begin
        case ($urandom_range(0, 3))
          0: add(cisd_pkg::OP_RESTORE_EXT);
          1: add(cisd_pkg::OP_UNDEFINED);
          2: add(cisd_pkg::OP_SAME_VALUE);
          default: add(cisd_pkg::OP_DEF_CFA_REG);
        endcase
        add_uleb(rand_value(), $urandom_range(0, 7) == 0 ? 5 : 0);
      end
      10: begin
        add($urandom_range(0, 1) ? cisd_pkg::OP_REGISTER : cisd_pkg::OP_DEF_CFA);
        add_uleb(rand_value(), 0);
        add_uleb(rand_value(), 0);
      end
      11: begin
        add(cisd_pkg::OP_DEF_CFA_OFF);
        add_uleb(rand_value(), 0);
      end
      12, 13: begin
        len = $urandom_range(0, 5);
        case ($urandom_range(0, 2))
          0: add(cisd_pkg::OP_DEF_CFA_EXPR);
          1: begin
            add(cisd_pkg::OP_EXPRESSION);
            add_uleb(rand_value(), 0);
          end
          default: begin
            add(cisd_pkg::OP_VAL_EXPR);
            add_uleb(rand_value(), 0);
          end
        endcase
        add_uleb(64'(len), 0);
        repeat (len) add(8'($urandom));
      end
      14: add(8'($urandom_range(0, 63)));
      default: repeat ($urandom_range(1, 3)) add(8'($urandom));
    endcase
    // End the stream at the instruction end, or cut it short now and then
    if ($urandom_range(0, 24) == 0) begin
      cut = $urandom_range(start, stream.size() - 1);
      while (stream.size() > cut + 1) void'(stream.pop_back());
      stream[cut].end_of_stream = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stream[stream.size() - 1].end_of_stream = 1'b1;
    end
  endfunction

  task send_byte(cisd_pkg::byte_item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= it;
    do @(posedge clk); while (!byte_ready);
    sb.note_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_stream();
    while (stream.size() > 0) send_byte(stream.pop_front());
    byte_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every expected record is back, then let the pipeline settle
  task drain();
    while (sb.pending_records.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_reg(bit [7:0] index, bit [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    bit [15:0] code_set[4];
    bit [15:0] data_set[4];
    bit [15:0] limit_set[4];
    sb = new();
    sb.reset_state();
    calm = 0;
    bytes_sent = 0;
    rx_stall = 0;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    rec_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every opcode form plus the stream-end corner cases
    add(8'h41); add(8'h7f);
    add(cisd_pkg::OP_ADVANCE1); add(8'hff);
    add(cisd_pkg::OP_ADVANCE2); add(8'h34); add(8'h12);
    add(cisd_pkg::OP_ADVANCE4); add(8'hff); add(8'hff); add(8'hff); add(8'hff);
    add(8'h85); add(8'h04);
    add(8'hc3);
    add(cisd_pkg::OP_OFFSET_EXT); add(8'h07); add(8'h10);
    add(cisd_pkg::OP_RESTORE_EXT); add(8'h90); add(8'h01);
    add(cisd_pkg::OP_UNDEFINED); add(8'h01);
    add(cisd_pkg::OP_SAME_VALUE); add(8'h02);
    add(cisd_pkg::OP_DEF_CFA_REG); add(8'h05);
    add(cisd_pkg::OP_REGISTER); add(8'h01); add(8'h02);
    add(cisd_pkg::OP_DEF_CFA); add(8'h07); add(8'h08);
    add(cisd_pkg::OP_DEF_CFA_EXPR); add(8'h02); add(8'haa); add(8'hbb);
    add(cisd_pkg::OP_EXPRESSION); add(8'h03); add(8'h00);
    add(cisd_pkg::OP_VAL_EXPR); add(8'h01); add(8'h01); add(8'hcc);
    add(cisd_pkg::OP_OFFSET_SF); add(8'h04); add(8'h7f);
    add(8'h00); add(8'h0a); add(8'h3f);
    // Long LEB with bits past bit 63
    add(cisd_pkg::OP_DEF_CFA_OFF);
    repeat (10) add(8'hff);
    add(8'h01);
    // Truncated instruction, then a block overrun, then end on a full record
    add(cisd_pkg::OP_OFFSET_EXT); add(8'h07, 1);
    add(cisd_pkg::OP_DEF_CFA_EXPR); add(8'h05); add(8'h11); add(8'h22, 1);
    add(8'hc1, 1);
    send_stream();
    drain();

    // Random phases under several register settings, extremes included
    code_set = '{16'd0, 16'hffff, 16'd4, 16'd1};
    data_set = '{16'h8000, 16'h7fff, 16'hfffc, 16'hfff8};
    limit_set = '{16'd0, 16'd5, 16'hffff, 16'd40};
    for (int p = 0; p < 4; p++) begin
      write_reg(cisd_pkg::CFG_CODE_ALIGN, p == 3 ? 16'($urandom) : code_set[p]);
      write_reg(cisd_pkg::CFG_DATA_ALIGN, p == 3 ? 16'($urandom) : data_set[p]);
      write_reg(cisd_pkg::CFG_MAX_RECORDS, limit_set[p]);
      calm = (p == 3);
      while (stream.size() < 200) add_random_instr();
      // Pause mid-phase until the decoder has caught up
      if (p == 1) begin
        for (int k = 0; k < 100; k++) send_byte(stream.pop_front());
        byte_valid <= 1'b0;
        while (sb.pending_records.size() != 0) @(negedge clk);
      end
      send_stream();
      drain();
    end

    $display("sent %0d stream bytes over 4 register settings, checked %0d records",
             bytes_sent, sb.records_seen);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cisd_pkg.sv
sv/cisd_front.sv
sv/cisd_fifo.sv
sv/cisd_back.sv
sv/cfi_instruction_stream_decoder.sv
sv/cisd_checker.sv
test/tb_cfi_instruction_stream_decoder.sv
